[sv/acm_pkg.sv]
// ============================================================================
// acm_pkg
// Shared types and constants of the multi-pattern matcher.
// ============================================================================
package acm_pkg;

   // Default sizes
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int MAX_NODES_DEF     = 1024;
   localparam int MAX_PATTERNS_DEF  = 64;
   localparam int POSITION_BITS_DEF = 32;

   // Fixed field widths
   localparam int SYM_W     = 5;
   localparam int OP_W      = 2;
   localparam int PAT_W     = 7;
   localparam int IDX_W     = 6;
   localparam int OUT_POS_W = 32;

   // Pattern id meaning "no pattern"
   localparam logic [PAT_W-1:0] PAT_NONE = 7'd127;

   localparam logic KIND_MATCH    = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_SCAN  = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef struct packed {
      logic                 kind;
      logic [IDX_W-1:0]     idx;
      logic [OUT_POS_W-1:0] pos;
      logic                 last;
   } result_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE,
      ST_L_ADDR, ST_L_READ, ST_L_PAT, ST_OVF,
      ST_B_POP, ST_B_NODE, ST_B_FAIL, ST_B_SYM, ST_B_A1, ST_B_A2, ST_B_A3,
      ST_B_E1, ST_B_E2,
      ST_S_ADDR, ST_S_READ, ST_S_HEAD, ST_S_CHAIN, ST_S_EMIT
   } state_type;

endpackage

[sv/aho_corasick_multi_pattern_matcher.sv]
// Load: a word follows or creates a trie edge; a pattern end then closes it.
// Scan: a word steps the automaton, then emits one match word per chain entry.
// Build: breadth-first; fills each empty edge and links and enqueues each child.
// Throughput: one word at a time; a full output register stalls the walk.
// Reset: synchronous; afterwards a clearing pass empties the transition,
// first-pattern and output-head tables, and req_tready stays low until it ends.
// ============================================================================
// aho_corasick_multi_pattern_matcher
// Multi-pattern matcher top level: sequencer plus output register.
// ============================================================================
module aho_corasick_multi_pattern_matcher #(
   parameter int ALPHABET_SIZE = acm_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_NODES     = acm_pkg::MAX_NODES_DEF,
   parameter int MAX_PATTERNS  = acm_pkg::MAX_PATTERNS_DEF,
   parameter int POSITION_BITS = acm_pkg::POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] symbol, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        req_tlast,   // pattern_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [5:0] pattern_index, [37:6] start_position
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last_match
);
   import acm_pkg::*;

   logic       res_push;
   logic       res_ready;
   result_type res;
   result_type out_ff;
   logic       out_valid_ff;

   acm_ctrl #(
      .ALPHABET_SIZE(ALPHABET_SIZE), .MAX_NODES(MAX_NODES),
      .MAX_PATTERNS(MAX_PATTERNS), .POSITION_BITS(POSITION_BITS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser), .in_sym(req_tdata[SYM_W-1:0]), .in_pend(req_tlast),
      .res_push(res_push), .res_ready(res_ready), .res(res)
   );

   // Output register is free when empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Hold the result word
   always_ff @(posedge clock) begin
      if (res_push) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.pos, out_ff.idx};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule

[sv/acm_ram.sv]
// ============================================================================
// acm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module acm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/acm_addr_unit.sv]
// ============================================================================
// acm_addr_unit
// Shared transition-table address unit: node * alphabet size + symbol,
// registered, loaded on a strobe and held otherwise.
// ============================================================================
module acm_addr_unit #(
   parameter int ALPHABET_SIZE = 26,
   parameter int NW            = 10,
   parameter int IW            = 5,
   parameter int GW            = 15
) (
   input  logic          clock,
   input  logic          go,
   input  logic [NW-1:0] node,
   input  logic [IW-1:0] sym,
   output logic [GW-1:0] addr
);

   logic [GW-1:0] addr_ff;
   logic [GW-1:0] addr_in;

   // Multiply-add of the row base and column
   always_comb begin
      addr_in = GW'(node) * GW'(ALPHABET_SIZE) + GW'(sym);
   end

   always_ff @(posedge clock) begin
      if (go) begin
         addr_ff <= addr_in;
      end
   end

   assign addr = addr_ff;

endmodule

[sv/acm_ctrl.sv]
// ============================================================================
// acm_ctrl
// Sequencer of the matcher: trie load, breadth-first build, and scan with
// output chain walk. Owns the table memories and the shared address unit.
// ============================================================================
module acm_ctrl #(
   parameter int ALPHABET_SIZE = 26,
   parameter int MAX_NODES     = 1024,
   parameter int MAX_PATTERNS  = 64,
   parameter int POSITION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [acm_pkg::OP_W-1:0]  in_op,
   input  logic [acm_pkg::SYM_W-1:0] in_sym,
   input  logic                      in_pend,
   output logic                      res_push,
   input  logic                      res_ready,
   output acm_pkg::result_type       res
);
   import acm_pkg::*;

   localparam int NW     = $clog2(MAX_NODES);
   localparam int NCW    = $clog2(MAX_NODES + 1);
   localparam int IW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int GDEPTH = MAX_NODES * ALPHABET_SIZE;
   localparam int GW     = $clog2(GDEPTH);
   localparam int PAW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PSW    = POSITION_BITS;

   state_type state_ff, state_in;

   // Control registers
   logic              ovf_ff, ovf_in;
   logic              built_ff, built_in;
   logic [NCW-1:0]    node_cnt_ff, node_cnt_in;
   logic [PAT_W-1:0]  pat_cnt_ff, pat_cnt_in;
   logic [NW-1:0]     cur_node_ff, cur_node_in;
   logic [NCW-1:0]    cur_len_ff, cur_len_in;
   logic [PSW-1:0]    pos_ff, pos_in;
   logic [GW-1:0]     clr_ff, clr_in;
   logic [NCW-1:0]    qh_ff, qh_in, qt_ff, qt_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [PAT_W-1:0]  k_ff, k_in;

   // Payload registers
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              pend_ff, pend_in;
   logic [NW-1:0]     n_ff, n_in, prev_ff, prev_in, y_ff, y_in;
   logic [GW-1:0]     slot_ff, slot_in;
   logic [NW:0]       gslot_ff, gslot_in;
   logic [PAT_W-1:0]  oh_ed_ff, oh_ed_in, fp_ed_ff, fp_ed_in, p_ff, p_in;

   // Address unit
   logic              a_go;
   logic [NW-1:0]     a_node;
   logic [IW-1:0]     a_sym;
   logic [GW-1:0]     a_addr;

   // Memory ports
   logic              g_we;
   logic [GW-1:0]     g_wa, g_ra;
   logic [NW:0]       g_wd, g_rd;
   logic              f_we;
   logic [NW-1:0]     f_wa, f_wd, f_ra, f_rd;
   logic              fp_we, oh_we;
   logic [NW-1:0]     fp_wa, fp_ra, oh_wa, oh_ra;
   logic [PAT_W-1:0]  fp_wd, fp_rd, oh_wd, oh_rd;
   logic              nc_we, pl_we;
   logic [PAW-1:0]    nc_wa, nc_ra, pl_wa, pl_ra;
   logic [PAT_W-1:0]  nc_wd, nc_rd;
   logic [NCW-1:0]    pl_wd, pl_rd;
   logic              q_we;
   logic [NW-1:0]     q_wa, q_wd, q_ra, q_rd;

   // Scratch values
   logic              sym_bad;
   logic [NW-1:0]     nxt;
   logic [NW-1:0]     y_now;
   logic              last_now;
   logic [PSW-1:0]    start_pos;
   logic [63:0]       start_wide;

   acm_addr_unit #(
      .ALPHABET_SIZE(ALPHABET_SIZE), .NW(NW), .IW(IW), .GW(GW)
   ) u_addr (
      .clock(clock), .go(a_go), .node(a_node), .sym(a_sym), .addr(a_addr)
   );

   acm_ram #(.WIDTH(NW + 1), .DEPTH(GDEPTH), .AW(GW)) u_goto (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(g_ra), .rd_data(g_rd)
   );
   acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NW)) u_fail (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd)
   );
   acm_ram #(.WIDTH(PAT_W), .DEPTH(MAX_NODES), .AW(NW)) u_first (
      .clock(clock), .wr_en(fp_we), .wr_addr(fp_wa), .wr_data(fp_wd),
      .rd_addr(fp_ra), .rd_data(fp_rd)
   );
   acm_ram #(.WIDTH(PAT_W), .DEPTH(MAX_NODES), .AW(NW)) u_head (
      .clock(clock), .wr_en(oh_we), .wr_addr(oh_wa), .wr_data(oh_wd),
      .rd_addr(oh_ra), .rd_data(oh_rd)
   );
   acm_ram #(.WIDTH(PAT_W), .DEPTH(MAX_PATTERNS), .AW(PAW)) u_chain (
      .clock(clock), .wr_en(nc_we), .wr_addr(nc_wa), .wr_data(nc_wd),
      .rd_addr(nc_ra), .rd_data(nc_rd)
   );
   acm_ram #(.WIDTH(NCW), .DEPTH(MAX_PATTERNS), .AW(PAW)) u_len (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
      .rd_addr(pl_ra), .rd_data(pl_rd)
   );
   acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NW)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd)
   );

   // Match start position, folded to the 32-bit result field
   always_comb begin
      start_pos  = pos_ff - PSW'(pl_rd) + PSW'(1);
      start_wide = 64'(start_pos);
   end

   // Next state, memory strobes and result
   always_comb begin
      state_in    = state_ff;
      ovf_in      = ovf_ff;
      built_in    = built_ff;
      node_cnt_in = node_cnt_ff;
      pat_cnt_in  = pat_cnt_ff;
      cur_node_in = cur_node_ff;
      cur_len_in  = cur_len_ff;
      pos_in      = pos_ff;
      clr_in      = clr_ff;
      qh_in       = qh_ff;
      qt_in       = qt_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      op_in       = op_ff;
      sym_in      = sym_ff;
      pend_in     = pend_ff;
      n_in        = n_ff;
      prev_in     = prev_ff;
      y_in        = y_ff;
      slot_in     = slot_ff;
      gslot_in    = gslot_ff;
      oh_ed_in    = oh_ed_ff;
      fp_ed_in    = fp_ed_ff;
      p_in        = p_ff;

      in_ready = 1'b0;
      res_push = 1'b0;
      res      = '{kind: KIND_MATCH, idx: '0, pos: '0, last: 1'b0};

      a_go   = 1'b0;
      a_node = cur_node_ff;
      a_sym  = IW'(sym_ff);

      g_we = 1'b0;  g_wa = a_addr;  g_wd = '0;  g_ra = a_addr;
      f_we = 1'b0;  f_wa = '0;      f_wd = '0;  f_ra = '0;
      fp_we = 1'b0; fp_wa = cur_node_ff; fp_wd = PAT_NONE; fp_ra = '0;
      oh_we = 1'b0; oh_wa = cur_node_ff; oh_wd = PAT_NONE; oh_ra = '0;
      nc_we = 1'b0; nc_wa = '0; nc_wd = '0; nc_ra = PAW'(p_ff);
      pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_ra = PAW'(p_ff);
      q_we = 1'b0;  q_wa = '0;  q_wd = '0;  q_ra = NW'(qh_ff);

      sym_bad  = 32'(sym_ff) >= 32'(ALPHABET_SIZE);
      nxt      = g_rd[NW-1:0];
      y_now    = (n_ff == '0) ? '0 : g_rd[NW-1:0];
      last_now = (32'(nc_rd) >= 32'(MAX_PATTERNS)) || (k_ff == PAT_W'(MAX_PATTERNS - 1));

      unique case (state_ff)
         // Sweep the tables to their empty state
         ST_CLEAR: begin
            g_we = 1'b1;
            g_wa = clr_ff;
            g_wd = '0;
            if (32'(clr_ff) < 32'(MAX_NODES)) begin
               fp_we = 1'b1;
               fp_wa = NW'(clr_ff);
               oh_we = 1'b1;
               oh_wa = NW'(clr_ff);
            end
            if (clr_ff == GW'(GDEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + GW'(1);
            end
         end

         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in    = in_op;
               sym_in   = in_sym;
               pend_in  = in_pend;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            unique case (op_ff)
               OP_LOAD: begin
                  if (!built_ff && !ovf_ff && !sym_bad) begin
                     a_go     = 1'b1;
                     state_in = ST_L_ADDR;
                  end
               end
               OP_BUILD: begin
                  if (!built_ff) begin
                     q_we     = 1'b1;
                     qh_in    = '0;
                     qt_in    = NCW'(1);
                     state_in = ST_B_POP;
                  end
               end
               OP_SCAN: begin
                  if (built_ff && !sym_bad) begin
                     a_go     = 1'b1;
                     state_in = ST_S_ADDR;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // Load: follow or create the edge, then close a pattern that ends here
         ST_L_ADDR: state_in = ST_L_READ;

         ST_L_READ: begin
            if (!g_rd[NW] && node_cnt_ff == NCW'(MAX_NODES)) begin
               ovf_in      = 1'b1;
               cur_node_in = '0;
               cur_len_in  = '0;
               state_in    = ST_OVF;
            end else begin
               if (!g_rd[NW]) begin
                  nxt         = NW'(node_cnt_ff);
                  g_we        = 1'b1;
                  g_wd        = {1'b1, NW'(node_cnt_ff)};
                  node_cnt_in = node_cnt_ff + NCW'(1);
               end
               fp_ra = nxt;
               oh_ra = nxt;
               if (pend_ff && pat_cnt_ff == PAT_W'(MAX_PATTERNS)) begin
                  ovf_in      = 1'b1;
                  cur_node_in = '0;
                  cur_len_in  = '0;
                  state_in    = ST_OVF;
               end else begin
                  cur_node_in = nxt;
                  cur_len_in  = cur_len_ff + NCW'(1);
                  state_in    = pend_ff ? ST_L_PAT : ST_IDLE;
               end
            end
         end

         ST_L_PAT: begin
            fp_we       = (fp_rd == PAT_NONE);
            fp_wd       = pat_cnt_ff;
            nc_we       = 1'b1;
            nc_wa       = PAW'(pat_cnt_ff);
            nc_wd       = oh_rd;
            oh_we       = 1'b1;
            oh_wd       = pat_cnt_ff;
            pl_we       = 1'b1;
            pl_wa       = PAW'(pat_cnt_ff);
            pl_wd       = cur_len_ff;
            pat_cnt_in  = pat_cnt_ff + PAT_W'(1);
            cur_node_in = '0;
            cur_len_in  = '0;
            state_in    = ST_IDLE;
         end

         ST_OVF: begin
            res = '{kind: KIND_OVERFLOW, idx: '0, pos: '0, last: 1'b1};
            if (res_ready) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // Build: pop a node from the queue
         ST_B_POP: begin
            if (qh_ff < qt_ff) begin
               state_in = ST_B_NODE;
            end else begin
               built_in    = 1'b1;
               cur_node_in = '0;
               cur_len_in  = '0;
               state_in    = ST_IDLE;
            end
         end

         ST_B_NODE: begin
            n_in     = q_rd;
            f_ra     = q_rd;
            qh_in    = qh_ff + NCW'(1);
            state_in = ST_B_FAIL;
         end

         ST_B_FAIL: begin
            prev_in  = (n_ff == '0) ? '0 : f_rd;
            i_in     = '0;
            state_in = ST_B_SYM;
         end

         ST_B_SYM: begin
            a_go     = 1'b1;
            a_node   = n_ff;
            a_sym    = i_ff;
            state_in = ST_B_A1;
         end

         ST_B_A1: begin
            slot_in  = a_addr;
            a_go     = 1'b1;
            a_node   = prev_ff;
            a_sym    = i_ff;
            state_in = ST_B_A2;
         end

         ST_B_A2: begin
            gslot_in = g_rd;
            state_in = ST_B_A3;
         end

         ST_B_A3: begin
            y_in = y_now;
            if (!gslot_ff[NW]) begin
               g_we = 1'b1;
               g_wa = slot_ff;
               g_wd = {1'b1, y_now};
               if (i_ff == IW'(ALPHABET_SIZE - 1)) begin
                  state_in = ST_B_POP;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_B_SYM;
               end
            end else begin
               f_we     = 1'b1;
               f_wa     = gslot_ff[NW-1:0];
               f_wd     = y_now;
               oh_ra    = gslot_ff[NW-1:0];
               fp_ra    = gslot_ff[NW-1:0];
               state_in = ST_B_E1;
            end
         end

         ST_B_E1: begin
            oh_ed_in = oh_rd;
            fp_ed_in = fp_rd;
            oh_ra    = y_ff;
            state_in = ST_B_E2;
         end

         // Merge the suffix chain and enqueue the child
         ST_B_E2: begin
            if (oh_ed_ff == PAT_NONE) begin
               oh_we = 1'b1;
               oh_wa = gslot_ff[NW-1:0];
               oh_wd = oh_rd;
            end else if (32'(fp_ed_ff) < 32'(MAX_PATTERNS)) begin
               nc_we = 1'b1;
               nc_wa = PAW'(fp_ed_ff);
               nc_wd = oh_rd;
            end
            if (qt_ff < NCW'(MAX_NODES)) begin
               q_we  = 1'b1;
               q_wa  = NW'(qt_ff);
               q_wd  = gslot_ff[NW-1:0];
               qt_in = qt_ff + NCW'(1);
            end
            if (i_ff == IW'(ALPHABET_SIZE - 1)) begin
               state_in = ST_B_POP;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_B_SYM;
            end
         end

         // Scan: step the automaton, then walk the output chain
         ST_S_ADDR: state_in = ST_S_READ;

         ST_S_READ: begin
            cur_node_in = nxt;
            oh_ra       = nxt;
            state_in    = ST_S_HEAD;
         end

         ST_S_HEAD: begin
            if (32'(oh_rd) >= 32'(MAX_PATTERNS)) begin
               pos_in   = pos_ff + PSW'(1);
               state_in = ST_IDLE;
            end else begin
               p_in     = oh_rd;
               k_in     = '0;
               state_in = ST_S_CHAIN;
            end
         end

         ST_S_CHAIN: state_in = ST_S_EMIT;

         ST_S_EMIT: begin
            res = '{kind: KIND_MATCH, idx: p_ff[IDX_W-1:0],
                    pos: start_wide[OUT_POS_W-1:0], last: last_now};
            if (res_ready) begin
               res_push = 1'b1;
               if (last_now) begin
                  pos_in   = pos_ff + PSW'(1);
                  state_in = ST_IDLE;
               end else begin
                  p_in     = nc_rd;
                  k_in     = k_ff + PAT_W'(1);
                  state_in = ST_S_CHAIN;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ovf_ff      <= 1'b0;
         built_ff    <= 1'b0;
         node_cnt_ff <= NCW'(1);
         pat_cnt_ff  <= '0;
         cur_node_ff <= '0;
         cur_len_ff  <= '0;
         pos_ff      <= '0;
         clr_ff      <= '0;
         qh_ff       <= '0;
         qt_ff       <= '0;
         i_ff        <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         ovf_ff      <= ovf_in;
         built_ff    <= built_in;
         node_cnt_ff <= node_cnt_in;
         pat_cnt_ff  <= pat_cnt_in;
         cur_node_ff <= cur_node_in;
         cur_len_ff  <= cur_len_in;
         pos_ff      <= pos_in;
         clr_ff      <= clr_in;
         qh_ff       <= qh_in;
         qt_ff       <= qt_in;
         i_ff        <= i_in;
         k_ff        <= k_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      sym_ff   <= sym_in;
      pend_ff  <= pend_in;
      n_ff     <= n_in;
      prev_ff  <= prev_in;
      y_ff     <= y_in;
      slot_ff  <= slot_in;
      gslot_ff <= gslot_in;
      oh_ed_ff <= oh_ed_in;
      fp_ed_ff <= fp_ed_in;
      p_ff     <= p_in;
   end

endmodule

[sv/acm_checker.sv]
// ============================================================================
// acm_checker
// Port-level checks of the matcher, bound to the top level.
// ============================================================================
module acm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Overflow report is a single empty last word
   a_ovf_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 40'd0)
      else $error("malformed overflow report");

   // Clearing pass keeps the input closed after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input open right after reset");

   // One word at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

endmodule

bind aho_corasick_multi_pattern_matcher acm_checker u_acm_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
